// ===== hdl/skh_pkg.sv =====
// ----------------------------------------------------------------------------
// skh_pkg
// Shared types, constants and round functions of the salted 256-bit key hash.
// ----------------------------------------------------------------------------
package skh_pkg;

  // key and lane geometry
  localparam int WORD_W     = 32;
  localparam int KEY_WORDS  = 8;
  localparam int FIELD_W    = 64;
  localparam int NUM_FIELDS = 4;
  localparam int KEY_BYTES  = KEY_WORDS * WORD_W / 8;

  localparam logic [WORD_W-1:0] LANE_BASE = 32'hdeadbeef;
  localparam logic [WORD_W-1:0] INIT_LANE_RESET = LANE_BASE + WORD_W'(KEY_BYTES);

  // configuration register map
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SALT_0_1    = 3'd0,
    REG_SALT_2_3    = 3'd1,
    REG_SALT_4_5    = 3'd2,
    REG_SALT_6_7    = 3'd3,
    REG_INIT_LANE   = 3'd4
  } reg_idx_t;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] words_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
  } lanes_t;

  // configuration handed from the register block to the datapath
  typedef struct packed {
    logic [NUM_FIELDS-1:0][FIELD_W-1:0] salt;
    word_t                              init_lane;
  } cfg_t;

  // micro-op sequence: mix round, add words 3..5, mix round, add words 6..7, final
  localparam int NUM_OPS       = 21;
  localparam int OPS_PER_STAGE = 2;
  localparam int NUM_OP_STAGES = (NUM_OPS + OPS_PER_STAGE - 1) / OPS_PER_STAGE;
  localparam int NUM_STAGES    = NUM_OP_STAGES + 1;
  localparam int OP_IDX_W      = $clog2(NUM_OP_STAGES * OPS_PER_STAGE);

  localparam int MIX1_FIRST  = 0;
  localparam int ADD345_OP   = 6;
  localparam int MIX2_FIRST  = 7;
  localparam int ADD67_OP    = 13;
  localparam int FINAL_FIRST = 14;

  typedef logic [OP_IDX_W-1:0] op_idx_t;

  typedef enum logic [2:0] {
    OP_MIX,
    OP_ADD_345,
    OP_ADD_67,
    OP_FINAL,
    OP_NONE
  } op_kind_t;

  function automatic word_t rotl(word_t v, int k);
    return (v << k) | (v >> (WORD_W - k));
  endfunction

  function automatic op_kind_t op_kind(op_idx_t i);
    int n;
    n = int'(i);
    if (n < ADD345_OP) return OP_MIX;
    else if (n == ADD345_OP) return OP_ADD_345;
    else if (n < ADD67_OP) return OP_MIX;
    else if (n == ADD67_OP) return OP_ADD_67;
    else if (n < NUM_OPS) return OP_FINAL;
    else return OP_NONE;
  endfunction

  function automatic int mix_rot(int p);
    case (p)
      0:       return 4;
      1:       return 6;
      2:       return 8;
      3:       return 16;
      4:       return 19;
      default: return 4;
    endcase
  endfunction

  function automatic int final_rot(int p);
    case (p)
      0:       return 14;
      1:       return 11;
      2:       return 25;
      3:       return 16;
      4:       return 4;
      5:       return 14;
      default: return 24;
    endcase
  endfunction

  // one hash step on the three lanes; x is updated from z, and a mix adds y to z
  function automatic lanes_t apply_op(lanes_t l, op_idx_t i, words_t w);
    lanes_t   r;
    op_kind_t kind;
    word_t    x;
    word_t    y;
    word_t    z;
    int       n;
    int       p;
    int       k;
    int       role;
    r    = l;
    kind = op_kind(i);
    n    = int'(i);
    x    = '0;
    y    = '0;
    z    = '0;
    case (kind)
      OP_ADD_345: begin
        r.a = l.a + w[3];
        r.b = l.b + w[4];
        r.c = l.c + w[5];
      end
      OP_ADD_67: begin
        r.a = l.a + w[6];
        r.b = l.b + w[7];
      end
      OP_MIX, OP_FINAL: begin
        if (kind == OP_MIX) begin
          p    = (n < MIX2_FIRST) ? n - MIX1_FIRST : n - MIX2_FIRST;
          k    = mix_rot(p);
          role = p % 3;
        end else begin
          p    = n - FINAL_FIRST;
          k    = final_rot(p);
          role = (p + 2) % 3;
        end
        // pick lane roles
        case (role)
          0:       begin x = l.a; y = l.b; z = l.c; end
          1:       begin x = l.b; y = l.c; z = l.a; end
          default: begin x = l.c; y = l.a; z = l.b; end
        endcase
        if (kind == OP_MIX) begin
          x = (x - z) ^ rotl(z, k);
          z = z + y;
        end else begin
          x = (x ^ z) - rotl(z, k);
        end
        // put lanes back
        case (role)
          0:       begin r.a = x; r.b = y; r.c = z; end
          1:       begin r.b = x; r.c = y; r.a = z; end
          default: begin r.c = x; r.a = y; r.b = z; end
        endcase
      end
      default: r = l;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/skh_core.sv =====
// ----------------------------------------------------------------------------
// skh_core
// Pipelined hash datapath: salt and lane setup, then two hash steps per stage.
// ----------------------------------------------------------------------------
module skh_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  skh_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [skh_pkg::FIELD_W-1:0] in_key_words_0_1,
  input  logic [skh_pkg::FIELD_W-1:0] in_key_words_2_3,
  input  logic [skh_pkg::FIELD_W-1:0] in_key_words_4_5,
  input  logic [skh_pkg::FIELD_W-1:0] in_key_words_6_7,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [skh_pkg::FIELD_W-1:0] out_hash_value
);

  localparam int LAST = skh_pkg::NUM_STAGES - 1;

  logic                          advance;
  logic [skh_pkg::NUM_STAGES-1:0] valid_r;
  logic [skh_pkg::NUM_STAGES-1:0] valid_nxt;
  skh_pkg::lanes_t               lanes_r   [skh_pkg::NUM_STAGES];
  skh_pkg::lanes_t               lanes_nxt [skh_pkg::NUM_STAGES];
  skh_pkg::words_t               words_r   [skh_pkg::NUM_STAGES];
  skh_pkg::words_t               words_nxt [skh_pkg::NUM_STAGES];
  logic [skh_pkg::NUM_FIELDS-1:0][skh_pkg::FIELD_W-1:0] salted;

  // whole pipeline holds while the result in the last stage is stalled
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // stage 0 salts the key and seeds the lanes, later stages take two hash steps each
  always_comb begin
    salted[0] = in_key_words_0_1 ^ cfg.salt[0];
    salted[1] = in_key_words_2_3 ^ cfg.salt[1];
    salted[2] = in_key_words_4_5 ^ cfg.salt[2];
    salted[3] = in_key_words_6_7 ^ cfg.salt[3];
    words_nxt[0]   = skh_pkg::words_t'(salted);
    lanes_nxt[0].a = cfg.init_lane + words_nxt[0][0];
    lanes_nxt[0].b = cfg.init_lane + words_nxt[0][1];
    lanes_nxt[0].c = cfg.init_lane + words_nxt[0][2];
    for (int s = 1; s < skh_pkg::NUM_STAGES; s++) begin
      lanes_nxt[s] = skh_pkg::apply_op(
        skh_pkg::apply_op(lanes_r[s-1],
                          skh_pkg::op_idx_t'(skh_pkg::OPS_PER_STAGE * (s - 1)),
                          words_r[s-1]),
        skh_pkg::op_idx_t'(skh_pkg::OPS_PER_STAGE * (s - 1) + 1),
        words_r[s-1]);
      words_nxt[s] = words_r[s-1];
    end
  end

  assign valid_nxt = {valid_r[skh_pkg::NUM_STAGES-2:0], in_valid};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (advance) begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance) begin
      lanes_r <= lanes_nxt;
      words_r <= words_nxt;
    end
  end

  assign out_valid      = valid_r[LAST];
  assign out_hash_value = {lanes_r[LAST].b, lanes_r[LAST].c};

  // pipeline freezes completely under a stalled result
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(valid_r))
    else $error("pipeline moved while result stalled");

  // an accepted request lands in stage 0
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> valid_r[0])
    else $error("accepted request lost at pipeline entry");

  // a new result comes from the stage before the output
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(valid_r[LAST-1]))
    else $error("result appeared without a request behind it");

endmodule

// ===== hdl/salted_key_hash_256.sv =====
// ----------------------------------------------------------------------------
// salted_key_hash_256
// Salted lookup3-style hash of a 256-bit key into a 64-bit value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries the key as four 64-bit fields,
//   each holding two 32-bit key words, even word in the low half. A request is
//   taken on a clock edge with in_valid high and in_stall low.
//   Result channel (out_valid / out_stall) returns hash_value, lane b in the
//   upper 32 bits and lane c in the lower 32 bits, one result per request.
//   Configuration writes use cfg_valid / cfg_ready (always ready) with
//   cfg_index selecting salt words 0_1, 2_3, 4_5, 6_7 or the initial lane
//   value; other indexes are ignored. Write only while no request is in flight.
// Timing:
//   12 register stages: a salting and seeding stage, then eleven stages of two
//   hash steps each. An accepted request enters the salting stage, and out_valid
//   rises when it reaches the last hash stage; one request per cycle is taken
//   whenever the result is not stalled.
//   A stalled result freezes the whole pipeline, so in_stall follows it.
// Reset:
//   Pipeline empties; salts clear to zero and the initial lane value returns
//   to 0xdeadbf0f.
// ----------------------------------------------------------------------------
module salted_key_hash_256 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [skh_pkg::FIELD_W-1:0]          in_key_words_0_1,
  input  logic [skh_pkg::FIELD_W-1:0]          in_key_words_2_3,
  input  logic [skh_pkg::FIELD_W-1:0]          in_key_words_4_5,
  input  logic [skh_pkg::FIELD_W-1:0]          in_key_words_6_7,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [skh_pkg::FIELD_W-1:0]          out_hash_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [skh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [skh_pkg::FIELD_W-1:0]          cfg_data
);

  skh_pkg::cfg_t cfg_r;
  skh_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (skh_pkg::reg_idx_t'(cfg_index))
        skh_pkg::REG_SALT_0_1:  cfg_nxt.salt[0]   = cfg_data;
        skh_pkg::REG_SALT_2_3:  cfg_nxt.salt[1]   = cfg_data;
        skh_pkg::REG_SALT_4_5:  cfg_nxt.salt[2]   = cfg_data;
        skh_pkg::REG_SALT_6_7:  cfg_nxt.salt[3]   = cfg_data;
        skh_pkg::REG_INIT_LANE: cfg_nxt.init_lane = cfg_data[skh_pkg::WORD_W-1:0];
        default:                cfg_nxt           = cfg_r;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.salt      <= '0;
      cfg_r.init_lane <= skh_pkg::INIT_LANE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  skh_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_words_0_1 (in_key_words_0_1),
    .in_key_words_2_3 (in_key_words_2_3),
    .in_key_words_4_5 (in_key_words_4_5),
    .in_key_words_6_7 (in_key_words_6_7),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hash_value   (out_hash_value)
  );

endmodule
